### rtl/trial_division_prime_counter_assert.svh
// Assertion macros for the trial division prime counter.
// Included by the top level; expects a clock named clk and reset arst_n in scope.
`ifndef TRIAL_DIVISION_PRIME_COUNTER_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_COUNTER_ASSERT_SVH

// Same-cycle implication.
`define TDPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TDPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tdpc_pkg.sv
// Package for the trial division prime counter: control word types,
// microprogram ROM and shared constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdpc_pkg;

	localparam int unsigned COUNT_W = 32;
	localparam int unsigned CAND_W  = 32;
	localparam int unsigned TWO     = 2;
	localparam int unsigned THREE   = 3;
	localparam int unsigned STEP_W  = 4;

	typedef logic [STEP_W-1:0] step_t;
	typedef logic [COUNT_W-1:0] count_t;

	localparam count_t COUNT_MAX = '1;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_CLASSIFY,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_SET_PRIME,
		OP_SET_COMP,
		OP_NEXT_D,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_ITEM,
		C_TRIVIAL,
		C_DIV_BUSY,
		C_D_GT_Q,
		C_REM_ZERO,
		C_OUT_FULL
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		logic in_fire;
		logic trivial;
		logic div_busy;
		logic d_gt_q;
		logic rem_zero;
		logic out_full;
	} status_t;

	localparam step_t ST_IDLE     = step_t'(0);
	localparam step_t ST_CLASSIFY = step_t'(1);
	localparam step_t ST_DIV_INIT = step_t'(2);
	localparam step_t ST_DIV_STEP = step_t'(3);
	localparam step_t ST_TEST_END = step_t'(4);
	localparam step_t ST_TEST_REM = step_t'(5);
	localparam step_t ST_NEXT     = step_t'(6);
	localparam step_t ST_WAIT     = step_t'(7);
	localparam step_t ST_EMIT     = step_t'(8);

	function automatic ctrl_t rom_word(input step_t step);
		ctrl_t w;
		unique case (step)
			ST_IDLE:     w = '{op: OP_LOAD,      cond: C_NO_ITEM,  target: ST_IDLE};
			ST_CLASSIFY: w = '{op: OP_CLASSIFY,  cond: C_TRIVIAL,  target: ST_WAIT};
			ST_DIV_INIT: w = '{op: OP_DIV_INIT,  cond: C_NEVER,    target: ST_IDLE};
			ST_DIV_STEP: w = '{op: OP_DIV_STEP,  cond: C_DIV_BUSY, target: ST_DIV_STEP};
			ST_TEST_END: w = '{op: OP_SET_PRIME, cond: C_D_GT_Q,   target: ST_WAIT};
			ST_TEST_REM: w = '{op: OP_SET_COMP,  cond: C_REM_ZERO, target: ST_WAIT};
			ST_NEXT:     w = '{op: OP_NEXT_D,    cond: C_ALWAYS,   target: ST_DIV_INIT};
			ST_WAIT:     w = '{op: OP_NOP,       cond: C_OUT_FULL, target: ST_WAIT};
			ST_EMIT:     w = '{op: OP_EMIT,      cond: C_ALWAYS,   target: ST_IDLE};
			default:     w = '{op: OP_NOP,       cond: C_ALWAYS,   target: ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### rtl/tdpc_in_if.sv
// Input channel of the trial division prime counter: candidate transactions.
// Depends on tdpc_pkg for the candidate width.
`timescale 1ns / 1ps
`default_nettype none

interface tdpc_in_if;
	import tdpc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [CAND_W-1:0] candidate;
	logic                     first_of_list;

	modport source (output valid, output candidate, output first_of_list, input ready);
	modport sink (input valid, input candidate, input first_of_list, output ready);
endinterface

`default_nettype wire

### rtl/tdpc_out_if.sv
// Output channel of the trial division prime counter: result transactions.
// Depends on tdpc_pkg for the count width.
`timescale 1ns / 1ps
`default_nettype none

interface tdpc_out_if;
	import tdpc_pkg::*;

	logic               valid;
	logic               ready;
	logic               is_prime;
	logic [COUNT_W-1:0] primes_so_far;

	modport source (output valid, output is_prime, output primes_so_far, input ready);
	modport sink (input valid, input is_prime, input primes_so_far, output ready);
endinterface

`default_nettype wire

### rtl/trial_division_prime_counter.sv
// Trial division prime counter, top level.
// Channels: item (candidate, first_of_list) in, result (is_prime, primes_so_far) out,
// each a valid/ready transaction that completes when both are high at a clock edge.
// Each candidate gives one result. Negative values, 0, 1, 2 and even values take the
// short path: classify, wait for the output register to empty, emit the result and
// return to the idle step to take the next candidate.
// Otherwise each odd trial divisor that does not end the test runs a divider init, the
// one-bit-per-cycle shift-subtract divider, an end test, a remainder test and a step to
// the next odd divisor. A prime ends once the divisor exceeds the quotient; a composite
// ends when the remainder is zero at its smallest odd factor.
// One candidate is worked on at a time; the next is taken once the microprogram
// returns to its idle step, while the previous result may still wait in the
// output register.
// first_of_list clears the running count before the candidate is counted; the
// count saturates at all ones.
// Reset clears the step counter, the count and the result valid.
// A stalled receiver holds the result; the block finishes the next candidate and
// then waits for the output register to empty.
`timescale 1ns / 1ps
`default_nettype none

`include "trial_division_prime_counter_assert.svh"

module trial_division_prime_counter
	import tdpc_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tdpc_in_if.sink    item,
	tdpc_out_if.source result
);

	ctrl_t   ctrl;
	status_t status;

	tdpc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	tdpc_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.status (status),
		.item   (item),
		.result (result)
	);

	`TDPC_ASSERT_NEXT(a_busy_after_accept, item.valid && item.ready, !item.ready, "ready after accept")
	`TDPC_ASSERT_NOW(a_emit_into_empty, ctrl.op == OP_EMIT, !status.out_full, "emit into full output")
	`TDPC_ASSERT_NOW(a_prime_counted, result.valid && result.is_prime, result.primes_so_far != '0, "prime with zero count")

endmodule

`default_nettype wire

### rtl/tdpc_seq.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on tdpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdpc_seq
	import tdpc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire status_t status,
	output      ctrl_t   ctrl
);

	step_t step_q;
	step_t step_next;
	logic  take;

	assign ctrl = rom_word(step_q);

	always_comb begin
		unique case (ctrl.cond)
			C_NEVER:    take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_ITEM:  take = !status.in_fire;
			C_TRIVIAL:  take = status.trivial;
			C_DIV_BUSY: take = status.div_busy;
			C_D_GT_Q:   take = status.d_gt_q;
			C_REM_ZERO: take = status.rem_zero;
			C_OUT_FULL: take = status.out_full;
			default:    take = 1'b1;
		endcase
		step_next = take ? ctrl.target : step_q + step_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

`default_nettype wire

### rtl/tdpc_dp.sv
// Datapath: candidate and divisor registers, shift-subtract divider,
// prime flag, running count and result register. Depends on tdpc_pkg and the channels.
`timescale 1ns / 1ps
`default_nettype none

module tdpc_dp
	import tdpc_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire ctrl_t ctrl,
	output      status_t status,
	tdpc_in_if.sink    item,
	tdpc_out_if.source result
);

	localparam int unsigned VW  = VALUE_WIDTH;
	localparam int unsigned BIT_W = $clog2(VW);

	logic [VW-1:0]    v_q;
	logic [VW-1:0]    d_q;
	logic [VW-1:0]    quo_q;
	logic [VW-1:0]    rem_q;
	logic [BIT_W-1:0] bit_q;
	logic             first_q;
	logic             prime_q;
	logic             out_valid_q;
	logic             out_prime_q;
	count_t           out_count_q;
	count_t           count_q;

	logic             in_fire;
	logic [VW:0]      rem_sh;
	logic [VW:0]      rem_diff;
	count_t           count_base;
	count_t           count_next;

	assign item.ready = (ctrl.op == OP_LOAD);
	assign in_fire    = item.valid && item.ready;

	assign result.valid         = out_valid_q;
	assign result.is_prime      = out_prime_q;
	assign result.primes_so_far = out_count_q;

	assign rem_sh   = {rem_q, quo_q[VW-1]};
	assign rem_diff = rem_sh - {1'b0, d_q};

	assign count_base = first_q ? '0 : count_q;
	assign count_next = (prime_q && count_base != COUNT_MAX) ? count_base + count_t'(1)
		: count_base;

	always_comb begin
		status.in_fire  = in_fire;
		status.trivial  = v_q[VW-1] || (v_q <= VW'(1)) || (v_q == VW'(TWO)) || !v_q[0];
		status.div_busy = (bit_q != BIT_W'(VW - 1));
		status.d_gt_q   = (d_q > quo_q);
		status.rem_zero = (rem_q == '0);
		status.out_full = out_valid_q;
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_LOAD: begin
				if (in_fire) begin
					v_q     <= VW'($unsigned(item.candidate));
					first_q <= item.first_of_list;
				end
			end
			OP_CLASSIFY: begin
				prime_q <= (v_q == VW'(TWO));
				d_q     <= VW'(THREE);
			end
			OP_DIV_INIT: begin
				rem_q <= '0;
				quo_q <= v_q;
				bit_q <= '0;
			end
			OP_DIV_STEP: begin
				if (!rem_diff[VW]) begin
					rem_q <= rem_diff[VW-1:0];
				end else begin
					rem_q <= rem_sh[VW-1:0];
				end
				quo_q <= {quo_q[VW-2:0], !rem_diff[VW]};
				bit_q <= bit_q + BIT_W'(1);
			end
			OP_SET_PRIME: prime_q <= 1'b1;
			OP_SET_COMP:  prime_q <= 1'b0;
			OP_NEXT_D:    d_q <= d_q + VW'(TWO);
			OP_EMIT: begin
				out_prime_q <= prime_q;
				out_count_q <= count_next;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.op == OP_EMIT) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
